/* hdl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and character constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

   // Characters the decoder looks for or produces.
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_QMARK     = 8'h3F;
   localparam logic [15:0] ASCII_LIMIT   = 16'h0080;

   // Most decoded bytes one raw byte can release.
   localparam int BURST_DEPTH = 4;

   // Decoder mode; the fourth code is unused and acts as normal text.
   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_HEX  = 2'd2
   } mode_type;

   // Decoded bytes released by one raw byte.
   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] bytes;
      logic [2:0]                  count;
      logic                        last;
   } burst_type;

endpackage

`default_nettype wire

/* hdl/jsu_req_if.sv */
// ----------------------------------------------------------------------------
// jsu_req_if
// Raw byte channel into the unescaper: valid/ready with one raw byte a word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

/* hdl/jsu_rsp_if.sv */
// ----------------------------------------------------------------------------
// jsu_rsp_if
// Decoded byte channel out of the unescaper: valid/ready, one byte a word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

/* hdl/jsu_decoder.sv */
// ----------------------------------------------------------------------------
// jsu_decoder
// Escape decoding state machine. Turns one accepted raw byte into a burst of
// zero to four decoded bytes and advances the escape state.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decoder
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output burst_type       burst
);

   mode_type    mode_ff, mode_in;
   logic [2:0]  digits_ff, digits_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  held_ff [3];
   logic [7:0]  held_in [3];

   logic [15:0] acc_next;
   logic [2:0]  cnt;
   logic [7:0]  r0, r1, r2;
   logic [1:0]  tail_len;

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] m;
      m = c;
      if (c == CHAR_N) m = CHAR_LF;
      else if (c == CHAR_T) m = CHAR_TAB;
      else if (c == CHAR_R) m = CHAR_CR;
      return m;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      return v;
   endfunction

   // State registers; the held digit bytes need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         digits_ff <= 3'd0;
         acc_ff    <= 16'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // Next state and the burst released by the current raw byte.
   always_comb begin
      mode_in     = mode_ff;
      digits_in   = digits_ff;
      acc_in      = acc_ff;
      held_in     = held_ff;
      burst.bytes = '0;
      burst.last  = in_last;
      cnt         = 3'd0;
      acc_next    = {acc_ff[11:0], hex_value(in_byte)};

      // The short tail rescanned when the string ends inside a hex escape.
      r0       = (digits_ff == 3'd0) ? in_byte : held_ff[0];
      r1       = (digits_ff == 3'd1) ? in_byte : held_ff[1];
      r2       = in_byte;
      tail_len = 2'(digits_ff + 3'd1);

      unique case (mode_ff)
         MODE_ESC: begin
            if (in_byte == CHAR_U && !in_last) begin
               mode_in   = MODE_HEX;
               digits_in = 3'd0;
               acc_in    = 16'd0;
            end else begin
               burst.bytes[cnt[1:0]] = escape_map(in_byte);
               cnt = cnt + 3'd1;
               mode_in = MODE_TEXT;
            end
         end
         MODE_HEX: begin
            acc_in = acc_next;
            if (digits_ff >= 3'd3) begin
               burst.bytes[cnt[1:0]] = (acc_next < ASCII_LIMIT) ? acc_next[7:0] : CHAR_QMARK;
               cnt = cnt + 3'd1;
               mode_in   = MODE_TEXT;
               digits_in = 3'd0;
               acc_in    = 16'd0;
            end else if (in_last) begin
               // Give up on the escape: emit 'u', then decode the tail as text.
               burst.bytes[cnt[1:0]] = CHAR_U;
               cnt = cnt + 3'd1;
               if (r0 == CHAR_BACKSLASH && tail_len > 2'd1) begin
                  burst.bytes[cnt[1:0]] = escape_map(r1);
                  cnt = cnt + 3'd1;
                  if (tail_len == 2'd3) begin
                     burst.bytes[cnt[1:0]] = r2;
                     cnt = cnt + 3'd1;
                  end
               end else begin
                  burst.bytes[cnt[1:0]] = r0;
                  cnt = cnt + 3'd1;
                  if (tail_len >= 2'd2) begin
                     if (r1 == CHAR_BACKSLASH && tail_len == 2'd3) begin
                        burst.bytes[cnt[1:0]] = escape_map(r2);
                        cnt = cnt + 3'd1;
                     end else begin
                        burst.bytes[cnt[1:0]] = r1;
                        cnt = cnt + 3'd1;
                        if (tail_len == 2'd3) begin
                           burst.bytes[cnt[1:0]] = r2;
                           cnt = cnt + 3'd1;
                        end
                     end
                  end
               end
            end else begin
               held_in[digits_ff[1:0]] = in_byte;
               digits_in = digits_ff + 3'd1;
            end
         end
         default: begin
            if (in_byte == CHAR_BACKSLASH && !in_last) begin
               mode_in = MODE_ESC;
            end else begin
               burst.bytes[cnt[1:0]] = in_byte;
               cnt = cnt + 3'd1;
               mode_in = MODE_TEXT;
            end
         end
      endcase

      // The end of a string returns the decoder to normal text.
      if (in_last) begin
         mode_in   = MODE_TEXT;
         digits_in = 3'd0;
         acc_in    = 16'd0;
      end

      burst.count = cnt;
   end

endmodule

`default_nettype wire

/* hdl/jsu_burst_out.sv */
// ----------------------------------------------------------------------------
// jsu_burst_out
// Result register. Holds one burst of decoded bytes and hands them out one
// word a cycle while rsp_chan is ready, taking the next burst as the last byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_burst_out
   import jsu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire burst_type burst,
   output logic           can_load,
   jsu_rsp_if.source      rsp_chan
);

   logic [BURST_DEPTH-1:0][7:0] bytes_ff, bytes_in;
   logic [2:0]                  count_ff, count_in;
   logic                        last_ff, last_in;
   logic                        pop;

   assign pop      = (count_ff != 3'd0) && rsp_chan.ready;
   assign can_load = (count_ff == 3'd0) || ((count_ff == 3'd1) && rsp_chan.ready);

   // A new burst replaces the drained one; otherwise shift on each word.
   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load) begin
         bytes_in = burst.bytes;
         count_in = burst.count;
         last_in  = burst.last;
      end else if (pop) begin
         bytes_in = {8'h00, bytes_ff[BURST_DEPTH-1:1]};
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
   end

   // The end mark goes on the final byte of a burst that closed a string.
   assign rsp_chan.valid    = (count_ff != 3'd0);
   assign rsp_chan.out_byte = bytes_ff[0];
   assign rsp_chan.out_last = last_ff && (count_ff == 3'd1);

endmodule

`default_nettype wire

/* hdl/json_string_unescaper.sv */
// ----------------------------------------------------------------------------
// json_string_unescaper
// Streaming decoder for the body of a JSON string: resolves backslash and
// backslash-u escapes and marks the last decoded byte of each string.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Word               Handshake
//   req_chan   in         in_byte, in_last   valid/ready
//   rsp_chan   out        out_byte, out_last valid/ready
//
// A raw byte is decoded in the cycle it is accepted and its decoded bytes
// land in the result register at that edge. Plain text streams at one byte
// a cycle while rsp_chan is ready. A string that ends inside a backslash-u
// releases up to four bytes, which the result register hands out one a
// cycle while rsp_chan is ready; input waits until the last of them leaves.
// Reset is synchronous and returns the decoder to normal text. A stall on
// rsp_chan holds the current byte and drops req_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescaper
   import jsu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   burst_type burst;
   logic      can_load;
   logic      accept;

   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   // Escape decoding.
   jsu_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_chan.in_byte),
      .in_last (req_chan.in_last),
      .burst   (burst)
   );

   // Result register and byte serializer.
   jsu_burst_out u_burst_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .burst    (burst),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
